FILE: src/shbc_pkg.sv
// ----------------------------------------------------------------------------
// shbc_pkg : shared types and constants for the box-to-cells block
// Fixed-point widths, hash primes, queue entry layout and the floor/saturate
// helper used by the front end.
// ----------------------------------------------------------------------------
package shbc_pkg;

    // Configuration
    localparam int MAX_SPAN        = 4;
    localparam int COORD_FRAC_BITS = 8;
    localparam int RECIP_FRAC_BITS = 16;
    localparam int RECIP_W         = 17;
    localparam int COORD_W         = 32;
    localparam int CELL_W          = 24;
    localparam int HASH_W          = 32;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(6554);

    // Product of a coordinate and the reciprocal, and its floored form
    localparam int PROD_W     = COORD_W + RECIP_W + 1;
    localparam int FLOOR_SH   = COORD_FRAC_BITS + RECIP_FRAC_BITS;
    localparam int SHIFTED_W  = PROD_W - FLOOR_SH;
    localparam int SPAN_W     = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int DIFF_W     = CELL_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HASH_W-1:0] HASH_PX = 32'h8da6b343;
    localparam logic [HASH_W-1:0] HASH_PY = 32'hd8163841;
    localparam logic [HASH_W-1:0] HASH_PZ = 32'hcb1ab31f;

    localparam logic signed [SHIFTED_W-1:0] SAT_HI = SHIFTED_W'(8388607);
    localparam logic signed [SHIFTED_W-1:0] SAT_LO = SHIFTED_W'(-8388608);

    typedef logic signed [CELL_W-1:0] cell_t;
    typedef logic [SPAN_W-1:0]        span_t;
    typedef logic [1:0]               axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    // One box after classification: min cell, hash of the min cell,
    // cell count minus one per axis, clip flag
    typedef struct packed {
        cell_t [2:0]       lo;
        logic [HASH_W-1:0] hash;
        span_t [2:0]       nm1;
        logic              clipped;
    } box_entry_t;

    function automatic logic [HASH_W-1:0] hash_prime(input axis_t axis);
        logic [HASH_W-1:0] p;
        unique case (axis)
            AXIS_X:  p = HASH_PX;
            AXIS_Y:  p = HASH_PY;
            AXIS_Z:  p = HASH_PZ;
            default: p = '0;
        endcase
        return p;
    endfunction

    // Floor is the arithmetic shift already applied; clamp to the cell range
    function automatic cell_t sat_cell(input logic signed [SHIFTED_W-1:0] v);
        cell_t c;
        if (v > SAT_HI)
            c = SAT_HI[CELL_W-1:0];
        else if (v < SAT_LO)
            c = SAT_LO[CELL_W-1:0];
        else
            c = v[CELL_W-1:0];
        return c;
    endfunction

endpackage

FILE: src/spatial_hash_box_cells.sv
// ----------------------------------------------------------------------------
// spatial_hash_box_cells : axis-aligned box to spatial hash grid cells
// Converts box corners to cell indexes and emits every covered cell with its
// prime-multiply hash.
// ----------------------------------------------------------------------------
// A box is taken as six signed Q23.8 corner coordinates. The front end runs
// the six corners one after another through a single 32x17 multiplier by the
// reciprocal cell size, floors and clamps each to a 24-bit cell index, hashes
// the min cell and classifies the box; the next box can be taken on the last
// step of that schedule. Classified boxes wait in a two-entry queue, and the
// back end emits one cell per cycle from its output register unless the
// output stalls. A box covers at most MAX_SPAN cells per axis. An inverted box
// yields no transfer at all. There is no clearing pass after reset. The only
// register, the reciprocal cell size, sits at byte address 0 and should only
// be written with the block idle.
// ----------------------------------------------------------------------------
module spatial_hash_box_cells (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [shbc_pkg::PADDR_W-1:0]          paddr,
    input  logic [shbc_pkg::PDATA_W-1:0]          pwdata,
    output logic [shbc_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,
    // box input
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [shbc_pkg::COORD_W-1:0]   min_x,
    input  logic signed [shbc_pkg::COORD_W-1:0]   min_y,
    input  logic signed [shbc_pkg::COORD_W-1:0]   min_z,
    input  logic signed [shbc_pkg::COORD_W-1:0]   max_x,
    input  logic signed [shbc_pkg::COORD_W-1:0]   max_y,
    input  logic signed [shbc_pkg::COORD_W-1:0]   max_z,
    // cell output
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [shbc_pkg::CELL_W-1:0]    cell_x,
    output logic signed [shbc_pkg::CELL_W-1:0]    cell_y,
    output logic signed [shbc_pkg::CELL_W-1:0]    cell_z,
    output logic signed [shbc_pkg::HASH_W-1:0]    cell_hash,
    output logic                                  last,
    output logic                                  clipped
);

    // Register index is the word address; only the reciprocal exists
    localparam logic REG_RECIP = 1'b0;

    logic [shbc_pkg::RECIP_W-1:0] recip_reg;
    logic                         cfg_write;
    logic                         push_valid;
    logic                         push_ready;
    shbc_pkg::box_entry_t         push_entry;
    logic                         pop_valid;
    logic                         pop_ready;
    shbc_pkg::box_entry_t         pop_entry;

    // Register file: writes land in the access phase, reads are combinational
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_RECIP)
                     ? shbc_pkg::PDATA_W'(recip_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            recip_reg <= shbc_pkg::RECIP_RESET;
        else if (cfg_write && (paddr[2] == REG_RECIP))
            recip_reg <= pwdata[shbc_pkg::RECIP_W-1:0];
    end

    // Front: corners to cells, classify, drop inverted boxes
    shbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .recip      (recip_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .min_x      (min_x),
        .min_y      (min_y),
        .min_z      (min_z),
        .max_x      (max_x),
        .max_y      (max_y),
        .max_z      (max_z),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Hold classified boxes so either side can stall on its own
    shbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Back: walk the cells and transfer one per cycle while the output is not stalled
    shbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_z     (cell_z),
        .cell_hash  (cell_hash),
        .last       (last),
        .clipped    (clipped)
    );

endmodule

FILE: src/shbc_front.sv
// ----------------------------------------------------------------------------
// shbc_front : corner-to-cell conversion and box classification
// Runs the six corners through one multiplier, floors and clamps them, hashes
// the min cell, then pushes a box entry or drops an inverted box.
// ----------------------------------------------------------------------------
module shbc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [shbc_pkg::RECIP_W-1:0]          recip,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [shbc_pkg::COORD_W-1:0]   min_x,
    input  logic signed [shbc_pkg::COORD_W-1:0]   min_y,
    input  logic signed [shbc_pkg::COORD_W-1:0]   min_z,
    input  logic signed [shbc_pkg::COORD_W-1:0]   max_x,
    input  logic signed [shbc_pkg::COORD_W-1:0]   max_y,
    input  logic signed [shbc_pkg::COORD_W-1:0]   max_z,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output shbc_pkg::box_entry_t                  push_entry
);

    typedef enum logic {
        FRONT_IDLE,
        FRONT_BUSY
    } front_state_t;

    localparam logic [2:0] LAST_STEP = 3'd7;
    localparam logic [2:0] MUL_LAST  = 3'd5;

    front_state_t state_reg;
    logic [2:0]   step_reg;

    logic signed [shbc_pkg::COORD_W-1:0]   coord_reg [6];
    logic signed [shbc_pkg::PROD_W-1:0]    prod_reg;
    shbc_pkg::cell_t                        cell_reg [6];
    logic [shbc_pkg::HASH_W-1:0]           hprod_reg;
    logic [shbc_pkg::HASH_W-1:0]           hash_reg;

    logic [2:0]                            mul_idx;
    logic signed [shbc_pkg::PROD_W-1:0]    mul_a;
    logic signed [shbc_pkg::PROD_W-1:0]    mul_b;
    logic [2:0]                            cell_idx;
    logic [2:0]                            hash_idx;
    shbc_pkg::cell_t                        hash_cell;
    logic [shbc_pkg::HASH_W-1:0]           hash_mul;
    logic                                  inverted;
    logic                                  advance;
    logic                                  at_last;
    logic                                  accept;
    shbc_pkg::box_entry_t                  entry;

    assign at_last = (state_reg == FRONT_BUSY) && (step_reg == LAST_STEP);
    assign advance = inverted || push_ready;
    assign in_ready = (state_reg == FRONT_IDLE) || (at_last && advance);
    assign accept = in_valid && in_ready;
    assign push_valid = at_last && !inverted;
    assign push_entry = entry;

    // Corner multiply: signed coordinate times unsigned reciprocal
    assign mul_idx  = (step_reg <= MUL_LAST) ? step_reg : 3'd0;
    assign mul_a    = shbc_pkg::PROD_W'(coord_reg[mul_idx]);
    assign mul_b    = shbc_pkg::PROD_W'({1'b0, recip});
    assign cell_idx = step_reg - 3'd1;
    assign hash_idx = step_reg - 3'd2;
    assign hash_cell = cell_reg[(hash_idx <= 3'd2) ? hash_idx : 3'd0];
    assign hash_mul  = shbc_pkg::HASH_W'(
        {{(shbc_pkg::HASH_W - shbc_pkg::CELL_W){hash_cell[shbc_pkg::CELL_W-1]}}, hash_cell}
        * shbc_pkg::hash_prime(hash_idx[1:0]));

    // Classify per axis: inverted, span, clip
    always_comb
    begin
        logic signed [shbc_pkg::DIFF_W-1:0] diff;
        inverted      = 1'b0;
        entry.clipped = 1'b0;
        entry.hash    = hash_reg;
        for (int a = 0; a < 3; a++)
        begin
            entry.lo[a] = cell_reg[a];
            diff = shbc_pkg::DIFF_W'(cell_reg[a + 3]) - shbc_pkg::DIFF_W'(cell_reg[a]);
            if (diff < 0)
                inverted = 1'b1;
            if (diff > shbc_pkg::DIFF_W'(shbc_pkg::MAX_SPAN - 1))
            begin
                entry.clipped = 1'b1;
                entry.nm1[a]  = shbc_pkg::SPAN_W'(shbc_pkg::MAX_SPAN - 1);
            end
            else
            begin
                entry.nm1[a] = diff[shbc_pkg::SPAN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            unique case (state_reg)
                FRONT_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= FRONT_BUSY;
                        step_reg  <= 3'd0;
                    end
                end
                FRONT_BUSY:
                begin
                    if (step_reg != LAST_STEP)
                        step_reg <= step_reg + 3'd1;
                    else if (advance)
                    begin
                        step_reg <= 3'd0;
                        if (!in_valid)
                            state_reg <= FRONT_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= FRONT_IDLE;
                end
            endcase
        end
    end

    // Datapath schedule: multiply on steps 0-5, floor on 1-6, hash multiply on 2-4, hash sum on 3-5
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coord_reg[0] <= min_x;
            coord_reg[1] <= min_y;
            coord_reg[2] <= min_z;
            coord_reg[3] <= max_x;
            coord_reg[4] <= max_y;
            coord_reg[5] <= max_z;
        end
        if (state_reg == FRONT_BUSY)
        begin
            if (step_reg <= MUL_LAST)
                prod_reg <= mul_a * mul_b;
            if (step_reg >= 3'd1 && step_reg <= 3'd6)
                cell_reg[cell_idx] <= shbc_pkg::sat_cell(
                    prod_reg[shbc_pkg::PROD_W-1:shbc_pkg::FLOOR_SH]);
            if (step_reg >= 3'd2 && step_reg <= 3'd4)
                hprod_reg <= hash_mul;
            if (step_reg == 3'd0)
                hash_reg <= '0;
            else if (step_reg >= 3'd3 && step_reg <= 3'd5)
                hash_reg <= hash_reg + hprod_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == FRONT_BUSY) && (step_reg == 3'd0))
        else $error("front did not restart its schedule on a new box");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FRONT_BUSY) && (step_reg != LAST_STEP) |-> !in_ready)
        else $error("front took a box before its schedule ended");

endmodule

FILE: src/shbc_queue.sv
// ----------------------------------------------------------------------------
// shbc_queue : short queue of classified boxes
// Decouples the front end from the cell walker.
// ----------------------------------------------------------------------------
module shbc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  shbc_pkg::box_entry_t push_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output shbc_pkg::box_entry_t pop_entry
);

    shbc_pkg::box_entry_t                 mem [shbc_pkg::QUEUE_DEPTH];
    logic [shbc_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [shbc_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [shbc_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic                                 push_fire;
    logic                                 pop_fire;

    assign push_ready = (count_reg != shbc_pkg::QUEUE_CNT_W'(shbc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push_fire && !pop_fire)
                count_reg <= count_reg + 1'b1;
            else if (pop_fire && !push_fire)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem[wr_ptr_reg] <= push_entry;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= shbc_pkg::QUEUE_CNT_W'(shbc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push_fire && !pop_fire |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue lost a pushed entry");

endmodule

FILE: src/shbc_back.sv
// ----------------------------------------------------------------------------
// shbc_back : cell walker
// Steps through the cells of one box, x outermost, z innermost, and keeps the
// hash up to date by adding the primes. Ends in the output register.
// ----------------------------------------------------------------------------
module shbc_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  shbc_pkg::box_entry_t                 pop_entry,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [shbc_pkg::CELL_W-1:0]   cell_x,
    output logic signed [shbc_pkg::CELL_W-1:0]   cell_y,
    output logic signed [shbc_pkg::CELL_W-1:0]   cell_z,
    output logic signed [shbc_pkg::HASH_W-1:0]   cell_hash,
    output logic                                 last,
    output logic                                 clipped
);

    logic                         active_reg;
    logic                         out_valid_reg;
    shbc_pkg::span_t              i_reg, j_reg, k_reg;
    shbc_pkg::span_t              nx_reg, ny_reg, nz_reg;
    shbc_pkg::cell_t              lo_y_reg, lo_z_reg;
    shbc_pkg::cell_t              cur_x_reg, cur_y_reg, cur_z_reg;
    logic [shbc_pkg::HASH_W-1:0]  hash_reg, row_reg, plane_reg;
    logic                         clip_reg;

    shbc_pkg::cell_t              cell_x_reg, cell_y_reg, cell_z_reg;
    logic [shbc_pkg::HASH_W-1:0]  cell_hash_reg;
    logic                         last_reg, clipped_reg;

    logic                         emit;
    logic                         is_last;
    logic                         load;

    assign emit      = active_reg && (!out_valid_reg || out_ready);
    assign is_last   = (i_reg == nx_reg) && (j_reg == ny_reg) && (k_reg == nz_reg);
    assign load      = pop_valid && (!active_reg || (emit && is_last));
    assign pop_ready = load;

    assign out_valid = out_valid_reg;
    assign cell_x    = cell_x_reg;
    assign cell_y    = cell_y_reg;
    assign cell_z    = cell_z_reg;
    assign cell_hash = cell_hash_reg;
    assign last      = last_reg;
    assign clipped   = clipped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (load)
            begin
                active_reg <= 1'b1;
                i_reg      <= '0;
                j_reg      <= '0;
                k_reg      <= '0;
            end
            else if (emit)
            begin
                if (is_last)
                    active_reg <= 1'b0;
                else if (k_reg != nz_reg)
                    k_reg <= k_reg + 1'b1;
                else if (j_reg != ny_reg)
                begin
                    j_reg <= j_reg + 1'b1;
                    k_reg <= '0;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= '0;
                    k_reg <= '0;
                end
            end
        end
    end

    // Cell coordinates and running hashes
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cell_x_reg    <= cur_x_reg;
            cell_y_reg    <= cur_y_reg;
            cell_z_reg    <= cur_z_reg;
            cell_hash_reg <= hash_reg;
            last_reg      <= is_last;
            clipped_reg   <= clip_reg;
        end
        if (load)
        begin
            nx_reg    <= pop_entry.nm1[0];
            ny_reg    <= pop_entry.nm1[1];
            nz_reg    <= pop_entry.nm1[2];
            lo_y_reg  <= pop_entry.lo[1];
            lo_z_reg  <= pop_entry.lo[2];
            cur_x_reg <= pop_entry.lo[0];
            cur_y_reg <= pop_entry.lo[1];
            cur_z_reg <= pop_entry.lo[2];
            hash_reg  <= pop_entry.hash;
            row_reg   <= pop_entry.hash;
            plane_reg <= pop_entry.hash;
            clip_reg  <= pop_entry.clipped;
        end
        else if (emit && !is_last)
        begin
            if (k_reg != nz_reg)
            begin
                cur_z_reg <= cur_z_reg + 1'b1;
                hash_reg  <= hash_reg + shbc_pkg::HASH_PZ;
            end
            else if (j_reg != ny_reg)
            begin
                cur_y_reg <= cur_y_reg + 1'b1;
                cur_z_reg <= lo_z_reg;
                row_reg   <= row_reg + shbc_pkg::HASH_PY;
                hash_reg  <= row_reg + shbc_pkg::HASH_PY;
            end
            else
            begin
                cur_x_reg <= cur_x_reg + 1'b1;
                cur_y_reg <= lo_y_reg;
                cur_z_reg <= lo_z_reg;
                plane_reg <= plane_reg + shbc_pkg::HASH_PX;
                row_reg   <= plane_reg + shbc_pkg::HASH_PX;
                hash_reg  <= plane_reg + shbc_pkg::HASH_PX;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("walker emitted a cell that never reached the output");

endmodule

FILE: dv/shbc_cell_monitor.sv
// ----------------------------------------------------------------------------
// shbc_cell_monitor : cell prediction and comparison for spatial_hash_box_cells
// Watches the register port and both channels. Every accepted box is expanded
// into the cells it covers. Each cell transfer is compared, field by field,
// with the oldest cell still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module shbc_cell_monitor (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [shbc_pkg::PADDR_W-1:0]          paddr,
    input  logic [shbc_pkg::PDATA_W-1:0]          pwdata,
    input  logic [shbc_pkg::PDATA_W-1:0]          prdata,
    input  logic                                  pready,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic signed [shbc_pkg::COORD_W-1:0]   min_x,
    input  logic signed [shbc_pkg::COORD_W-1:0]   min_y,
    input  logic signed [shbc_pkg::COORD_W-1:0]   min_z,
    input  logic signed [shbc_pkg::COORD_W-1:0]   max_x,
    input  logic signed [shbc_pkg::COORD_W-1:0]   max_y,
    input  logic signed [shbc_pkg::COORD_W-1:0]   max_z,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [shbc_pkg::CELL_W-1:0]    cell_x,
    input  logic signed [shbc_pkg::CELL_W-1:0]    cell_y,
    input  logic signed [shbc_pkg::CELL_W-1:0]    cell_z,
    input  logic signed [shbc_pkg::HASH_W-1:0]    cell_hash,
    input  logic                                  last,
    input  logic                                  clipped,
    output int                                    mismatch_count,
    output int                                    cells_owed
);

    import shbc_pkg::*;

    localparam int     RECIP_INDEX = 0;
    localparam longint CELL_HI     = 64'sd8388607;
    localparam longint CELL_LO     = -64'sd8388608;

    typedef struct packed {
        cell_t             x;
        cell_t             y;
        cell_t             z;
        logic [HASH_W-1:0] hash;
        logic              last;
        logic              clipped;
    } cell_item_t;

    cell_item_t         cells_due[$];
    cell_item_t         head;
    logic [RECIP_W-1:0] recip = RECIP_RESET;

    // Floor of coordinate times reciprocal, clamped to the 24-bit cell range
    function automatic cell_t floor_cell(input logic signed [COORD_W-1:0] coord,
                                         input logic [RECIP_W-1:0] r);
        longint prod;
        longint idx;
        prod = longint'(coord) * longint'(r);
        idx  = prod >>> FLOOR_SH;
        if (idx > CELL_HI)
            idx = CELL_HI;
        else if (idx < CELL_LO)
            idx = CELL_LO;
        return cell_t'(idx);
    endfunction

    function automatic logic [HASH_W-1:0] hash_cell(input cell_t x, input cell_t y,
                                                    input cell_t z);
        logic [HASH_W-1:0] xw;
        logic [HASH_W-1:0] yw;
        logic [HASH_W-1:0] zw;
        xw = {{(HASH_W - CELL_W){x[CELL_W-1]}}, x};
        yw = {{(HASH_W - CELL_W){y[CELL_W-1]}}, y};
        zw = {{(HASH_W - CELL_W){z[CELL_W-1]}}, z};
        return HASH_PX * xw + HASH_PY * yw + HASH_PZ * zw;
    endfunction

    // Queue every cell of the box, x outermost and z innermost
    task automatic expand_box(input logic [5:0][COORD_W-1:0] corner);
        cell_t      base [3];
        int         count [3];
        cell_t      lo_c;
        cell_t      hi_c;
        int         span;
        int         total;
        int         seen;
        logic       clip;
        cell_item_t item;
        clip = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            lo_c = floor_cell(corner[a], recip);
            hi_c = floor_cell(corner[a + 3], recip);
            // inverted on any axis: nothing at all
            if (hi_c < lo_c)
                return;
            span = int'(hi_c) - int'(lo_c) + 1;
            if (span > MAX_SPAN)
            begin
                span = MAX_SPAN;
                clip = 1'b1;
            end
            base[a]  = lo_c;
            count[a] = span;
        end
        total = count[0] * count[1] * count[2];
        seen  = 0;
        for (int i = 0; i < count[0]; i++)
            for (int j = 0; j < count[1]; j++)
                for (int k = 0; k < count[2]; k++)
                begin
                    item.x       = cell_t'(int'(base[0]) + i);
                    item.y       = cell_t'(int'(base[1]) + j);
                    item.z       = cell_t'(int'(base[2]) + k);
                    item.hash    = hash_cell(item.x, item.y, item.z);
                    seen++;
                    item.last    = (seen == total);
                    item.clipped = clip;
                    cells_due.push_back(item);
                end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t cell monitor: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip = RECIP_RESET;
            cells_due.delete();
            mismatch_count = 0;
            cells_owed     = 0;
        end
        else
        begin
            // retire the cell transfer before queueing a new box
            if (out_valid && out_ready)
            begin
                if (cells_due.size() == 0)
                    report_mismatch("cell with nothing owed", cell_hash, '0);
                else
                begin
                    head = cells_due.pop_front();
                    if (cell_x !== head.x)
                        report_mismatch("cell_x", cell_x, head.x);
                    if (cell_y !== head.y)
                        report_mismatch("cell_y", cell_y, head.y);
                    if (cell_z !== head.z)
                        report_mismatch("cell_z", cell_z, head.z);
                    if (cell_hash !== head.hash)
                        report_mismatch("cell_hash", cell_hash, head.hash);
                    if (last !== head.last)
                        report_mismatch("last", last, head.last);
                    if (clipped !== head.clipped)
                        report_mismatch("clipped", clipped, head.clipped);
                end
            end
            if (in_valid && in_ready)
                expand_box({max_z, max_y, max_x, min_z, min_y, min_x});
            if (psel && penable && pready && (paddr >> 2) == RECIP_INDEX)
            begin
                if (pwrite)
                    recip = pwdata[RECIP_W-1:0];
                else if (prdata !== PDATA_W'(recip))
                    report_mismatch("reciprocal readback", prdata, PDATA_W'(recip));
            end
            cells_owed = cells_due.size();
        end
    end

endmodule

FILE: dv/spatial_hash_box_cells_test.sv
// ----------------------------------------------------------------------------
// spatial_hash_box_cells_test : top-level bench for spatial_hash_box_cells
// Drives boxes and register writes, idles both channels at random and leaves
// prediction to shbc_cell_monitor. A directed opening covers field extremes,
// exact negative cell boundaries, saturation, zero reciprocal, inverted and
// clipped boxes; random phases then run under several reciprocal settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spatial_hash_box_cells_test;

    import shbc_pkg::*;

    localparam int     CLK_PERIOD      = 10;
    localparam int     RESET_CYCLES    = 12;
    // a box passes the front end, then queue and output register;
    // an inverted box leaves no trace in the owed count, so allow for it
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     PHASES          = 9;
    localparam int     BOXES_PER_PHASE = 42;
    localparam int     BURST_BOXES     = 12;
    localparam longint RUN_LIMIT_NS    = 64'd60_000_000;

    localparam logic [PADDR_W-1:0] RECIP_ADDR = 3'd0;
    localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;
    localparam logic               ACC_WRITE  = 1'b1;
    localparam logic               ACC_READ   = 1'b0;

    localparam int     COORD_HI   = 32'sh7fff_ffff;
    localparam int     COORD_LO   = 32'sh8000_0000;
    localparam int     RECIP_FULL = (1 << RECIP_W) - 1;

    typedef logic [5:0][COORD_W-1:0] box_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [COORD_W-1:0]  min_x;
    logic signed [COORD_W-1:0]  min_y;
    logic signed [COORD_W-1:0]  min_z;
    logic signed [COORD_W-1:0]  max_x;
    logic signed [COORD_W-1:0]  max_y;
    logic signed [COORD_W-1:0]  max_z;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [CELL_W-1:0]   cell_x;
    logic signed [CELL_W-1:0]   cell_y;
    logic signed [CELL_W-1:0]   cell_z;
    logic signed [HASH_W-1:0]   cell_hash;
    logic                       last;
    logic                       clipped;

    int                         mismatch_count;
    int                         cells_owed;

    // idling controls for the box sender and the cell sink
    bit                         src_steady;
    bit                         sink_steady;
    bit                         hold_off_req;
    logic [RECIP_W-1:0]         recip_now;

    spatial_hash_box_cells dut (.*);

    shbc_cell_monitor cell_monitor (.*);

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Idle lengths drawn from three ranges: mostly the shortest, now and then the longest
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic box_t corners(input int mnx, input int mny, input int mnz,
                                     input int mxx, input int mxy, input int mxz);
        return {mxz, mxy, mxx, mnz, mny, mnx};
    endfunction

    // Well-formed box sized to the current cell pitch: a few cells per axis,
    // anchored near the origin, anywhere, on exact boundaries, or against either end of
    // the coordinate range; now and then an axis is inverted
    function automatic box_t shaped_box();
        box_t   b;
        longint pitch;
        longint lo;
        longint hi;
        longint tmp;
        if (recip_now == 0)
            pitch = 64'sd4096;
        else
            pitch = (64'sd1 <<< FLOOR_SH) / longint'(recip_now);
        for (int a = 0; a < 3; a++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: lo = longint'($urandom_range(0, 16 * pitch)) - 8 * pitch;
                4, 5:       lo = longint'(int'($urandom()));
                6:          lo = (longint'($urandom_range(0, 16)) - 8) * pitch;
                7:          lo = longint'(COORD_HI) - longint'($urandom_range(0, 6 * pitch));
                8:          lo = longint'(COORD_LO) + longint'($urandom_range(0, 6 * pitch));
                default:    lo = (longint'($urandom_range(0, 16)) - 8) * pitch - 1;
            endcase
            hi = lo + longint'($urandom_range(0, 4)) * pitch
                    + longint'($urandom_range(0, pitch - 1));
            if (hi > longint'(COORD_HI))
                hi = longint'(COORD_HI);
            if ($urandom_range(0, 15) == 0)
            begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            b[a]     = lo[COORD_W-1:0];
            b[a + 3] = hi[COORD_W-1:0];
        end
        return b;
    endfunction

    // Offer one box from a falling edge; hold it until the transfer, then
    // maybe idle with scrambled payload. Returns on a falling edge.
    task automatic offer_box(input box_t corner);
        int gap;
        {max_z, max_y, max_x, min_z, min_y, min_x} = corner;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        gap = (src_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            {max_z, max_y, max_x, min_z, min_y, min_x} =
                {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            repeat (gap)
                @(negedge clk);
        end
    endtask

    task automatic random_box();
        if ($urandom_range(0, 99) < 85)
            offer_box(shaped_box());
        else
            offer_box({$urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom()});
    endtask

    // Setup cycle, then access cycle; the write lands at the access edge
    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drop valid, wait for every owed cell, then let the front end settle
    task automatic drain_cells();
        in_valid = 1'b0;
        wait (cells_owed == 0);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // Only ever written with the block idle; read back to check the port
    task automatic set_recip(input int value);
        drain_cells();
        reg_access(ACC_WRITE, RECIP_ADDR, PDATA_W'(value));
        reg_access(ACC_READ, RECIP_ADDR, '0);
        recip_now = value[RECIP_W-1:0];
    endtask

    // ------------------------------------------------------------------------
    // Cell sink: random back-pressure, plus a long hold-off on request so the
    // queue fills and the block stalls its box input
    // ------------------------------------------------------------------------
    initial
    begin : cell_sink
        int idle_left;
        idle_left = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            else if (idle_left > 0)
            begin
                out_ready = 1'b0;
                idle_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (!sink_steady && $urandom_range(0, 3) == 0)
                    idle_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Box stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin : box_stimulus
        bit saved_steady;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        {max_z, max_y, max_x, min_z, min_y, min_x} = '0;
        src_steady   = 1'b0;
        sink_steady  = 1'b0;
        hold_off_req = 1'b0;
        recip_now    = RECIP_RESET;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset reciprocal, about one tenth: 2560 raw is just over one cell
        reg_access(ACC_READ, RECIP_ADDR, '0);
        offer_box(corners(0, 0, 0, 0, 0, 0));
        offer_box(corners(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI));
        offer_box(corners(COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI));
        offer_box(corners(COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO));
        // inverted on x alone, then y alone, then z alone
        offer_box(corners(3 * 2560, 0, 0, 0, 2560, 2560));
        offer_box(corners(0, 2560, 0, 2560, -2560, 2560));
        offer_box(corners(0, 0, 5000, 2560, 2560, 0));
        // 3 x 2 x 4 cells, unclipped
        offer_box(corners(0, 0, 0, 2 * 2560 + 10, 2560, 3 * 2560 + 5));
        // five cells on x, cut to four
        offer_box(corners(0, -2560, 0, 4 * 2560, 0, 0));
        offer_box(corners(-1, -1, -1, 0, 0, 0));

        // unit cells: exact negative boundaries must floor into their own cell
        set_recip(1 << RECIP_FRAC_BITS);
        offer_box(corners(-256, -256, -256, -1, -1, -1));
        offer_box(corners(-257, -257, -257, 256, 256, 256));
        offer_box(corners(-256, -1, -255, -256, 255, 0));
        offer_box(corners(-512, 0, 0, 767, 0, 0));

        // largest reciprocal: corners beyond the cell range saturate
        set_recip(RECIP_FULL);
        offer_box(corners(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI));
        offer_box(corners(COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI));
        offer_box(corners(COORD_LO, COORD_LO, COORD_LO,
                          COORD_LO + 300, COORD_LO + 300, COORD_LO + 300));

        // zero reciprocal: every box collapses to cell 0, even a raw inversion
        set_recip(0);
        offer_box(corners(-5000, 7, COORD_HI, COORD_LO, 9, 0));
        offer_box(corners(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI));
        // a write beyond the only register must leave the reciprocal alone
        drain_cells();
        reg_access(ACC_WRITE, SPARE_ADDR, 32'h0000_0001);
        offer_box(corners(-100000, 0, 100000, 100000, 0, 200000));

        // smallest non-zero reciprocal
        set_recip(1);
        offer_box(corners(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI));
        offer_box(corners(-1, -1, -1, 0, 0, 0));

        // random phases, each with its own reciprocal and idling mix
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_recip(RECIP_RESET);
                1:       set_recip(1 << RECIP_FRAC_BITS);
                2:       set_recip(256);
                3:       set_recip(1);
                4:       set_recip(RECIP_FULL);
                5:       set_recip(0);
                default: set_recip($urandom_range(0, RECIP_FULL));
            endcase
            src_steady  = (p % 4 == 1);
            sink_steady = (p % 4 == 1) || (p % 4 == 2);

            // hold the sink off while boxes keep coming back to back
            if (p == 2)
            begin
                saved_steady = src_steady;
                src_steady   = 1'b1;
                hold_off_req = 1'b1;
                repeat (BURST_BOXES)
                    random_box();
                src_steady = saved_steady;
            end

            for (int i = 0; i < BOXES_PER_PHASE; i++)
            begin
                // once mid-phase, let the block empty completely
                if (p == 3 && i == BOXES_PER_PHASE / 2)
                    drain_cells();
                random_box();
            end
        end

        drain_cells();
        if (mismatch_count == 0 && cells_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
